### sv/sof_pkg.sv
// Shared types and constants for the substring occurrence finder.
package sof_pkg;

  localparam int PATTERN_MAX   = 16;
  localparam int POSITION_BITS = 16;
  localparam int LEN_W         = $clog2(PATTERN_MAX + 1);
  localparam int IDX_W         = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  localparam logic [7:0]               LEAD_BYTE = 8'hC3;
  localparam logic [POSITION_BITS-1:0] POS_MAX   = {POSITION_BITS{1'b1}};
  localparam logic [15:0]              MATCH_MAX = 16'hFFFF;

  // configuration register indexes
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DROP_LEAD    = 8'd3;

  // result kinds
  localparam logic KIND_MATCH   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // output queue
  localparam int OUTQ_DEPTH = 4;
  localparam int QPTR_W     = $clog2(OUTQ_DEPTH);
  localparam int QCNT_W     = $clog2(OUTQ_DEPTH + 1);

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } text_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [15:0] start_position;
    logic [15:0] end_position;
    logic [15:0] match_total;
    logic        position_overflow;
    logic        last_result;
  } result_item_t;

  typedef struct packed {
    logic [63:0] pattern_low_bytes;
    logic [63:0] pattern_high_bytes;
    logic [4:0]  pattern_length;
    logic        drop_lead_enable;
  } cfg_t;

  // up to two results per item, first_* is queued ahead of second_*
  typedef struct packed {
    logic         first_valid;
    logic         second_valid;
    result_item_t first_item;
    result_item_t second_item;
  } push_t;

endpackage

### sv/sof_matcher.sv
// Window, position counters and pattern compare for one text byte per cycle while proc is high.
module sof_matcher (
  input  logic                clk,
  input  logic                rst,
  input  sof_pkg::cfg_t       cfg,
  input  logic                proc,
  input  sof_pkg::text_item_t item,
  output sof_pkg::push_t      push
);
  import sof_pkg::*;

  logic [7:0]               window      [PATTERN_MAX];
  logic [7:0]               window_next [PATTERN_MAX];
  logic [POSITION_BITS-1:0] byte_position, byte_position_next;
  logic [LEN_W-1:0]         bytes_since_match, bytes_since_match_next;
  logic [15:0]              match_counter, match_counter_next;
  logic                     overflow_seen, overflow_seen_next;

  logic                     keep;
  logic                     eq;
  logic                     matched;
  logic [LEN_W-1:0]         len;
  logic [LEN_W-1:0]         bsm_inc;
  logic [POSITION_BITS-1:0] start_pos;
  logic [127:0]             pattern_all;

  assign pattern_all = {cfg.pattern_high_bytes, cfg.pattern_low_bytes};
  assign keep = !(cfg.drop_lead_enable && item.text_byte == LEAD_BYTE);
  assign len  = (cfg.pattern_length > 5'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                       : LEN_W'(cfg.pattern_length);

  always_comb begin
    window_next[0] = item.text_byte;
    for (int i = 1; i < PATTERN_MAX; i++) begin
      window_next[i] = window[i-1];
    end
  end

  assign bsm_inc = (bytes_since_match < LEN_W'(PATTERN_MAX)) ?
                   bytes_since_match + LEN_W'(1) : bytes_since_match;

  // pattern byte k lines up with window entry len-1-k
  always_comb begin
    logic [LEN_W-1:0] idx;
    eq  = 1'b1;
    idx = '0;
    for (int k = 0; k < PATTERN_MAX; k++) begin
      if (LEN_W'(k) < len) begin
        idx = len - LEN_W'(k) - LEN_W'(1);
        if (window_next[idx[IDX_W-1:0]] != pattern_all[8*k +: 8]) eq = 1'b0;
      end
    end
  end

  assign matched = keep && (len != '0) && (bsm_inc >= len) && eq;

  always_comb begin
    byte_position_next     = byte_position;
    overflow_seen_next     = overflow_seen;
    bytes_since_match_next = bytes_since_match;
    match_counter_next     = match_counter;
    if (keep) begin
      if (byte_position >= POS_MAX) overflow_seen_next = 1'b1;
      else byte_position_next = byte_position + POSITION_BITS'(1);
      bytes_since_match_next = matched ? '0 : bsm_inc;
      if (matched && match_counter < MATCH_MAX) match_counter_next = match_counter + 16'd1;
    end
  end

  assign start_pos = byte_position_next - POSITION_BITS'(len) + POSITION_BITS'(1);

  always_comb begin
    result_item_t m;
    result_item_t s;
    m.result_kind       = KIND_MATCH;
    m.start_position    = 16'(start_pos);
    m.end_position      = 16'(byte_position_next);
    m.match_total       = 16'd0;
    m.position_overflow = overflow_seen_next;
    m.last_result       = !item.end_of_text;
    s.result_kind       = KIND_SUMMARY;
    s.start_position    = 16'd0;
    s.end_position      = 16'd0;
    s.match_total       = match_counter_next;
    s.position_overflow = overflow_seen_next;
    s.last_result       = 1'b1;
    push.first_valid    = proc && (matched || item.end_of_text);
    push.second_valid   = proc && matched && item.end_of_text;
    push.first_item     = matched ? m : s;
    push.second_item    = s;
  end

  // window needs no clear: the since-match count gates every use of old entries
  always_ff @(posedge clk) begin
    if (proc && keep) window <= window_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      bytes_since_match <= '0;
      match_counter     <= '0;
      overflow_seen     <= 1'b0;
    end else if (proc) begin
      if (item.end_of_text) begin
        byte_position     <= '0;
        bytes_since_match <= '0;
        match_counter     <= '0;
        overflow_seen     <= 1'b0;
      end else begin
        byte_position     <= byte_position_next;
        bytes_since_match <= bytes_since_match_next;
        match_counter     <= match_counter_next;
        overflow_seen     <= overflow_seen_next;
      end
    end
  end

endmodule

### sv/sof_out_queue.sv
// Small result queue: takes up to two results a cycle, hands out one.
module sof_out_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  sof_pkg::push_t        push,
  output logic                  room,
  output logic                  result_valid,
  input  logic                  result_ready,
  output sof_pkg::result_item_t result_item
);
  import sof_pkg::*;

  result_item_t       entries [OUTQ_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]  count, count_next;
  logic [QCNT_W-1:0]  n_push;
  logic               pop;

  assign pop          = result_valid && result_ready;
  assign n_push       = QCNT_W'(push.first_valid) + QCNT_W'(push.second_valid);
  assign count_next   = count + n_push - QCNT_W'(pop);
  assign room         = count <= QCNT_W'(OUTQ_DEPTH - 2);
  assign result_valid = count != '0;
  assign result_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.first_valid) entries[wr_ptr] <= push.first_item;
    if (push.second_valid) entries[wr_ptr + QPTR_W'(1)] <= push.second_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(n_push);
      if (pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      count  <= count_next;
    end
  end

endmodule

### sv/substring_occurrence_finder.sv
// Top level of the streaming non-overlapping substring finder.
//
// Text bytes enter one item per cycle on the text channel. Each item first
// lands in a staging register; once the queue has room for two results
// the 16-byte window compare and the position/match counters settle it,
// and its results (a match report, an end-of-text summary, both, or none)
// drop into a four-entry result queue, from which the first result of an
// item can be taken. Sustained rate is one item per cycle as long as the
// result side keeps up; an item that yields two results needs two
// result handshakes, and the staging register holds when the queue has
// fewer than two free entries. With drop enabled, bytes equal to 0xC3 are
// skipped and take no position. Patterns are 1 to 16 bytes from the
// pattern registers, lengths above 16 act as 16, and a length of zero
// turns matching off. Configuration writes are always accepted and should
// only be issued while no text item is in flight.
module substring_occurrence_finder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            text_valid,
  output logic                            text_ready,
  input  sof_pkg::text_item_t             text_item,
  output logic                            result_valid,
  input  logic                            result_ready,
  output sof_pkg::result_item_t           result_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sof_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [63:0]                     cfg_data
);
  import sof_pkg::*;

  cfg_t       cfg;
  logic       stg_valid;
  text_item_t stg_item;
  logic       proc;
  logic       room;
  push_t      push;

  // config registers, write-only port
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_low_bytes  <= '0;
      cfg.pattern_high_bytes <= '0;
      cfg.pattern_length     <= '0;
      cfg.drop_lead_enable   <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PATTERN_LOW:  cfg.pattern_low_bytes  <= cfg_data;
        CFG_PATTERN_HIGH: cfg.pattern_high_bytes <= cfg_data;
        CFG_PATTERN_LEN:  cfg.pattern_length     <= cfg_data[4:0];
        CFG_DROP_LEAD:    cfg.drop_lead_enable   <= cfg_data[0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // staging register: processed once the queue can take two results
  assign proc       = stg_valid && room;
  assign text_ready = !stg_valid || proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (text_ready) begin
      stg_valid <= text_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text_valid && text_ready) stg_item <= text_item;
  end

  sof_matcher u_matcher (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .proc (proc),
    .item (stg_item),
    .push (push)
  );

  sof_out_queue u_out_queue (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .room         (room),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
  );

  // a summary always closes the item and carries no positions
  a_summary_form: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_item.result_kind == KIND_SUMMARY |->
      result_item.last_result && result_item.start_position == 16'd0 &&
      result_item.end_position == 16'd0)
    else $error("summary result malformed");

  // a match report carries no count and a forward span
  a_match_form: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_item.result_kind == KIND_MATCH |->
      result_item.match_total == 16'd0 &&
      result_item.end_position >= result_item.start_position)
    else $error("match report malformed");

  // a staged item held back by a full queue is kept intact
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    stg_valid && !proc |=> stg_valid && $stable(stg_item))
    else $error("staged item lost while stalled");

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for substring_occurrence_finder: directed and random tests.
module tb_top;
  import sof_pkg::*;

  // Watchdog limit, far longer than a full run even when every item gives two
  // results and both sides stall.
  localparam int unsigned CYCLE_LIMIT  = 50_000;
  // keep the log short if the block is badly broken
  localparam int unsigned MAX_REPORTED = 100;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 text_valid   = 1'b0;
  logic                 text_ready;
  text_item_t           text_item    = '0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  result_item_t         result_item;
  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [63:0]          cfg_data     = '0;

  // chance in percent that a side holds off in a given cycle
  int unsigned text_idle_pct   = 31;
  int unsigned result_idle_pct = 31;
  int unsigned errors          = 0;
  int unsigned cycles          = 0;

  // predictor copy of the configuration registers
  logic [127:0]             pattern     = '0;   // byte k at bits 8k+7:8k
  logic [4:0]               pattern_len = '0;
  logic                     drop_lead   = 1'b1;

  // predictor copy of the per-text state
  logic [7:0]               win_bytes [PATTERN_MAX];  // entry 0 is the newest byte
  logic [POSITION_BITS-1:0] text_pos;
  logic [LEN_W-1:0]         since_hit;
  logic [15:0]              hit_count;
  logic                     pos_saturated;

  // results still owed by the block, oldest first
  result_item_t pending_reports[$];

  substring_occurrence_finder dut (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_ready   (text_ready),
    .text_item    (text_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result side back-pressure, changed only on the falling edge.
  always @(negedge clk) begin
    result_ready <= ($urandom_range(99) >= result_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  task automatic clear_text_state();
    for (int i = 0; i < PATTERN_MAX; i++) win_bytes[i] = '0;
    text_pos      = '0;
    since_hit     = '0;
    hit_count     = '0;
    pos_saturated = 1'b0;
  endtask

  // Works out the results of one accepted text item and queues them.
  task automatic predict_reports(input text_item_t it);
    int unsigned  len;
    logic         hit;
    result_item_t r;
    hit = 1'b0;
    // lengths above the window size behave as a full window
    len = (pattern_len > PATTERN_MAX) ? PATTERN_MAX : pattern_len;

    // a dropped lead byte takes no position and stays out of the window
    if (!(drop_lead && it.text_byte == LEAD_BYTE)) begin
      for (int i = PATTERN_MAX - 1; i > 0; i--) win_bytes[i] = win_bytes[i-1];
      win_bytes[0] = it.text_byte;
      if (text_pos == POS_MAX) pos_saturated = 1'b1;
      else text_pos++;
      if (since_hit < PATTERN_MAX) since_hit++;
      // only bytes not claimed by an earlier match may form a new one
      if (len > 0 && since_hit >= len) begin
        hit = 1'b1;
        for (int k = 0; k < len; k++)
          if (win_bytes[len-1-k] != pattern[8*k +: 8]) hit = 1'b0;
        if (hit) begin
          since_hit = '0;
          if (hit_count != MATCH_MAX) hit_count++;
        end
      end
    end

    if (hit) begin
      r                   = '0;
      r.result_kind       = KIND_MATCH;
      r.end_position      = 16'(text_pos);
      r.start_position    = 16'(text_pos - len + 1);
      r.position_overflow = pos_saturated;
      r.last_result       = !it.end_of_text;
      pending_reports.push_back(r);
    end
    // the summary follows any match report, even when the final byte is dropped
    if (it.end_of_text) begin
      r                   = '0;
      r.result_kind       = KIND_SUMMARY;
      r.match_total       = hit_count;
      r.position_overflow = pos_saturated;
      r.last_result       = 1'b1;
      pending_reports.push_back(r);
      clear_text_state();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= MAX_REPORTED)
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_item_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_reports.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTED)
          $display("%0t: unexpected result: expected none, got kind=%0d start=%0d end=%0d total=%0d",
                   $time, result_item.result_kind, result_item.start_position,
                   result_item.end_position, result_item.match_total);
      end else begin
        want = pending_reports.pop_front();
        compare_field("result_kind",       want.result_kind,       result_item.result_kind);
        compare_field("start_position",    want.start_position,    result_item.start_position);
        compare_field("end_position",      want.end_position,      result_item.end_position);
        compare_field("match_total",       want.match_total,       result_item.match_total);
        compare_field("position_overflow", want.position_overflow,
                      result_item.position_overflow);
        compare_field("last_result",       want.last_result,       result_item.last_result);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers; every task is entered and left at a falling edge
  // ---------------------------------------------------------------------------

  // Sends one text item. Valid stays high into the next call, so back-to-back
  // items go out without a bubble; only an idle draw or wait_idle lowers it.
  task automatic send_text(input logic [7:0] b, input logic eot);
    text_item_t it;
    it.text_byte   = b;
    it.end_of_text = eot;
    while ($urandom_range(99) < text_idle_pct) begin
      text_valid <= 1'b0;
      @(negedge clk);
    end
    text_valid <= 1'b1;
    text_item  <= it;
    do @(posedge clk); while (!text_ready);
    predict_reports(it);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_PATTERN_LOW:  pattern[63:0]   = data;
      CFG_PATTERN_HIGH: pattern[127:64] = data;
      CFG_PATTERN_LEN:  pattern_len     = data[4:0];
      CFG_DROP_LEAD:    drop_lead       = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Stop sending and let the block drain. The extra cycles cover an item
  // with no result still sitting in the staging register.
  task automatic wait_idle();
    text_valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic load_config(input logic [63:0] lo, input logic [63:0] hi,
                             input logic [4:0] len, input logic drop);
    write_reg(CFG_PATTERN_LOW,  lo);
    write_reg(CFG_PATTERN_HIGH, hi);
    write_reg(CFG_PATTERN_LEN,  {59'd0, len});
    write_reg(CFG_DROP_LEAD,    {63'd0, drop});
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values: empty pattern never matches, lead bytes are dropped.
  task automatic test_reset_defaults();
    send_text(8'h41, 1'b0);
    send_text(LEAD_BYTE, 1'b0);
    send_text(8'h42, 1'b1);
    // final byte dropped: summary still comes and the state still clears
    send_text(LEAD_BYTE, 1'b1);
    wait_idle();
  endtask

  task automatic test_directed_matches();
    // "ABC" with a dropped lead byte inside a match, then a match on the
    // final byte so one item gives a report and a summary
    load_config(64'h0000_0000_0043_4241, '1, 5'd3, 1'b1);
    send_text(8'h41, 1'b0);
    send_text(8'h42, 1'b0);
    send_text(LEAD_BYTE, 1'b0);
    send_text(8'h43, 1'b0);
    send_text(8'h41, 1'b0);
    send_text(8'h42, 1'b0);
    send_text(8'h43, 1'b1);
    wait_idle();

    // "AA" over "AAAA": matches may not overlap
    load_config(64'h4141, 64'h0, 5'd2, 1'b1);
    repeat (3) send_text(8'h41, 1'b0);
    send_text(8'h41, 1'b1);
    wait_idle();

    // drop disabled: the lead byte is ordinary text and can match
    load_config(64'hC3, 64'h0, 5'd1, 1'b0);
    send_text(8'h00, 1'b0);
    send_text(8'hFF, 1'b0);
    send_text(LEAD_BYTE, 1'b1);
    wait_idle();
  endtask

  // Random texts built mostly from whole copies of the pattern, broken
  // prefixes and pattern bytes, with lead bytes and full-range noise mixed in.
  task automatic run_texts(input int unsigned quota);
    logic [7:0]  txt[$];
    int unsigned goal, sent, pick, cut, eff_len;
    sent    = 0;
    eff_len = (pattern_len > PATTERN_MAX) ? PATTERN_MAX : pattern_len;
    while (sent < quota) begin
      txt.delete();
      goal = ($urandom_range(19) == 0) ? $urandom_range(120, 60) : $urandom_range(24, 1);
      while (txt.size() < goal) begin
        pick = $urandom_range(99);
        if (eff_len != 0 && pick < 60) begin
          cut = (pick < 48) ? eff_len : $urandom_range(eff_len - 1, 0);
          for (int k = 0; k < cut; k++) begin
            if ($urandom_range(15) == 0) txt.push_back(LEAD_BYTE);
            txt.push_back(pattern[8*k +: 8]);
          end
        end else if (pick < 65) begin
          txt.push_back(LEAD_BYTE);
        end else if (pick < 80) begin
          txt.push_back(pattern[8*$urandom_range(PATTERN_MAX - 1) +: 8]);
        end else begin
          txt.push_back(8'($urandom_range(255)));
        end
      end
      foreach (txt[i]) send_text(txt[i], i == txt.size() - 1);
      sent += txt.size();
    end
  endtask

  task automatic test_random_phases();
    logic [4:0]  len;
    logic [63:0] lo, hi;
    for (int ph = 0; ph < 8; ph++) begin
      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
      case (ph)
        0:       len = 5'd16;
        1:       len = 5'd31;   // over-long, acts as a full window
        2:       len = 5'd0;    // matching off
        3:       len = 5'd17;
        4: begin
          len = 5'($urandom_range(8, 1));
          lo  = '0;
          hi  = '0;
        end
        5: begin
          len = 5'($urandom_range(8, 1));
          lo  = '1;
          hi  = '1;
        end
        default: len = 5'($urandom_range(8, 1));
      endcase
      load_config(lo, hi, len, ph[0]);
      // last phase runs at full rate on both sides
      if (ph == 7) begin
        text_idle_pct   = 0;
        result_idle_pct = 0;
      end
      run_texts(50);
      wait_idle();
      text_idle_pct   = 31;
      result_idle_pct = 31;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    clear_text_state();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_directed_matches();
    test_random_phases();

    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: timeout after %0d cycles", $time, cycles);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
